@@ sv/ppl_pkg.sv @@
// Shared types for the phone prefix range lookup: operation codes, the stored
// table word layout and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package ppl_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_WORD   = 2'd0,
    OP_LOAD_TARIFF = 2'd1,
    OP_SEARCH      = 2'd2,
    OP_CLEAR       = 2'd3
  } op_t;

  typedef struct packed {
    logic [33:0] value;
    logic        range_start;
    logic        entry_last;
    logic [7:0]  entry_id;
  } word_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic extend;
    logic prime;
    logic fetch;
    logic step;
    logic hit;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic done_pfx;
    logic cnt_zero;
    logic hit;
    logic last;
    logic out_free;
  } stat_t;

endpackage

@@ sv/ppl_ctrl.sv @@
// Controller for the phone prefix range lookup: sequences prefix extension and word scans.
// Depends on ppl_pkg.
`timescale 1ns / 1ps

module ppl_ctrl import ppl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output cmd_t       cmd,
  input  stat_t      stat
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_PRIME = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_PUSH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && (op_t'(in_op) == OP_SEARCH)) begin
          cmd.start = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.done_pfx) begin
          state_nxt = ST_PUSH;
        end else begin
          cmd.extend = 1'b1;
          state_nxt  = ST_PRIME;
        end
      end
      ST_PRIME: begin
        if (stat.cnt_zero) begin
          state_nxt = ST_CHECK;
        end else begin
          cmd.prime = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_PUSH;
        end else if (stat.last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/ppl_datapath.sv @@
// Datapath for the phone prefix range lookup: word table, word counts, tariff table,
// prefix builder, match logic and the result register. Depends on ppl_pkg.
`timescale 1ns / 1ps

module ppl_datapath import ppl_pkg::*; #(
  parameter int SLOT_COUNT     = 10,
  parameter int WORDS_PER_SLOT = 256,
  parameter int ENTRY_COUNT    = 256,
  parameter int MAX_DIGITS     = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_slot,
  input  logic [7:0]  in_word_addr,
  input  logic [33:0] in_number_value,
  input  logic        in_range_start,
  input  logic        in_entry_last,
  input  logic [7:0]  in_entry_id,
  input  logic [15:0] in_tariff_value,
  input  logic [39:0] in_phone_digits,
  input  logic [3:0]  in_digit_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [7:0]  out_match_entry,
  output logic [15:0] out_match_tariff,
  output logic [3:0]  out_prefix_length
);

  localparam int TOTAL   = SLOT_COUNT * WORDS_PER_SLOT;
  localparam int AW      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CW      = $clog2(WORDS_PER_SLOT + 1);
  localparam int SW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TW      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int LIM_MAX = (MAX_DIGITS < 10) ? MAX_DIGITS : 10;

  word_t       words_mem [TOTAL];
  logic [15:0] tariff_mem [ENTRY_COUNT];
  logic [CW-1:0] cnt_r [SLOT_COUNT];

  word_t         rdata_r;
  word_t         w_r;
  logic [15:0]   tar_rdata_r;
  logic [39:0]   phone_r;
  logic [33:0]   val_r;
  logic [3:0]    limit_r;
  logic [3:0]    k_r;
  logic          slot_ok_r;
  logic [AW-1:0] base_r;
  logic [CW-1:0] cnt_sel_r;
  logic [CW-1:0] idx_r;
  logic          found_r;
  logic [7:0]    hit_id_r;
  logic          tar_ok_r;
  logic          out_valid_r;
  logic          out_found_r;
  logic [7:0]    out_entry_r;
  logic [15:0]   out_tariff_r;
  logic [3:0]    out_len_r;

  logic          wr_word;
  logic          wr_tariff;
  logic [AW-1:0] wr_addr;
  word_t         wr_data;
  logic [3:0]    first;
  logic          first_ok;
  logic [3:0]    digit;
  logic [31:0]   rd_off;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          has_next;
  logic          hit_c;
  logic          id_ok;

  assign wr_word = cmd.accept && (op_t'(in_op) == OP_LOAD_WORD) &&
                   (32'(in_slot) < SLOT_COUNT) && (32'(in_word_addr) < WORDS_PER_SLOT);
  assign wr_tariff = cmd.accept && (op_t'(in_op) == OP_LOAD_TARIFF) &&
                     (32'(in_entry_id) < ENTRY_COUNT);
  assign wr_addr = AW'(32'(in_slot) * WORDS_PER_SLOT + 32'(in_word_addr));
  assign wr_data = '{value: in_number_value, range_start: in_range_start,
                     entry_last: in_entry_last, entry_id: in_entry_id};

  assign first    = in_phone_digits[39:36];
  assign first_ok = (32'(first) < SLOT_COUNT);
  assign digit    = phone_r[39:36];

  always_comb begin
    rd_off = 32'd0;
    if (cmd.fetch) begin
      rd_off = 32'd1;
    end else if (cmd.step) begin
      rd_off = 32'(idx_r) + 32'd2;
    end
  end

  assign rd_en   = (cmd.prime || cmd.fetch || cmd.step) && (rd_off < WORDS_PER_SLOT);
  assign rd_addr = AW'(32'(base_r) + rd_off);

  always_ff @(posedge clk) begin
    if (wr_word) begin
      words_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= words_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.accept && (op_t'(in_op) == OP_CLEAR)) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (wr_word) begin
      cnt_r[in_slot[SW-1:0]] <= CW'(32'(in_word_addr) + 32'd1);
    end
  end

  assign has_next = (32'(idx_r) + 32'd1) < 32'(cnt_sel_r);
  assign id_ok    = (32'(w_r.entry_id) < ENTRY_COUNT);

  always_comb begin
    if (w_r.range_start) begin
      hit_c = !w_r.entry_last && has_next && (w_r.value <= val_r) &&
              (rdata_r.range_start || (val_r <= rdata_r.value));
    end else begin
      hit_c = (w_r.value == val_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_tariff) begin
      tariff_mem[TW'(in_entry_id)] <= in_tariff_value;
    end
    if (cmd.hit && id_ok) begin
      tar_rdata_r <= tariff_mem[TW'(w_r.entry_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      phone_r   <= in_phone_digits;
      limit_r   <= (32'(in_digit_count) > LIM_MAX) ? 4'(LIM_MAX) : in_digit_count;
      k_r       <= '0;
      val_r     <= '0;
      found_r   <= 1'b0;
      slot_ok_r <= first_ok;
      base_r    <= AW'(32'(first) * WORDS_PER_SLOT);
      cnt_sel_r <= first_ok ? cnt_r[first[SW-1:0]] : '0;
    end
    if (cmd.extend) begin
      val_r   <= (val_r << 3) + (val_r << 1) + 34'(digit);
      k_r     <= k_r + 4'd1;
      phone_r <= phone_r << 4;
    end
    if (cmd.fetch) begin
      idx_r <= '0;
      w_r   <= rdata_r;
    end else if (cmd.step) begin
      idx_r <= idx_r + CW'(1);
      w_r   <= rdata_r;
    end
    if (cmd.hit) begin
      found_r  <= 1'b1;
      hit_id_r <= w_r.entry_id;
      tar_ok_r <= id_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_found_r  <= found_r;
      out_entry_r  <= found_r ? hit_id_r : 8'd0;
      out_tariff_r <= (found_r && tar_ok_r) ? tar_rdata_r : 16'd0;
      out_len_r    <= found_r ? k_r : 4'd0;
    end
  end

  assign stat.done_pfx = (k_r == limit_r) || (digit > 4'd9) || !slot_ok_r;
  assign stat.cnt_zero = (cnt_sel_r == '0);
  assign stat.hit      = hit_c;
  assign stat.last     = !has_next;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_entry   = out_entry_r;
  assign out_match_tariff  = out_tariff_r;
  assign out_prefix_length = out_len_r;

endmodule

@@ sv/phone_prefix_range_lookup.sv @@
// Phone prefix range lookup. Loads, tariff writes and count clears complete when accepted.
// A search tries each prefix length in turn and scans the slot of the first digit for it,
// with the single read port of the word table giving one word per cycle of the scan.
// One transaction at a time.
// Synchronous active-low reset clears the word counts and control; tables are undefined.
// Depends on ppl_pkg, ppl_ctrl and ppl_datapath.
`timescale 1ns / 1ps

module phone_prefix_range_lookup import ppl_pkg::*; #(
  parameter int SLOT_COUNT     = 10,
  parameter int WORDS_PER_SLOT = 256,
  parameter int ENTRY_COUNT    = 256,
  parameter int MAX_DIGITS     = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_slot,
  input  logic [7:0]  in_word_addr,
  input  logic [33:0] in_number_value,
  input  logic        in_range_start,
  input  logic        in_entry_last,
  input  logic [7:0]  in_entry_id,
  input  logic [15:0] in_tariff_value,
  input  logic [39:0] in_phone_digits,
  input  logic [3:0]  in_digit_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [7:0]  out_match_entry,
  output logic [15:0] out_match_tariff,
  output logic [3:0]  out_prefix_length
);

  cmd_t  cmd;
  stat_t stat;

  ppl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ppl_datapath #(
    .SLOT_COUNT     (SLOT_COUNT),
    .WORDS_PER_SLOT (WORDS_PER_SLOT),
    .ENTRY_COUNT    (ENTRY_COUNT),
    .MAX_DIGITS     (MAX_DIGITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_slot           (in_slot),
    .in_word_addr      (in_word_addr),
    .in_number_value   (in_number_value),
    .in_range_start    (in_range_start),
    .in_entry_last     (in_entry_last),
    .in_entry_id       (in_entry_id),
    .in_tariff_value   (in_tariff_value),
    .in_phone_digits   (in_phone_digits),
    .in_digit_count    (in_digit_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_entry   (out_match_entry),
    .out_match_tariff  (out_match_tariff),
    .out_prefix_length (out_prefix_length)
  );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for phone_prefix_range_lookup: directed and random table loads,
// tariff writes, clears and searches, with results checked against an in-bench lookup model.
// Depends on ppl_pkg and the phone_prefix_range_lookup RTL.
`timescale 1ns / 1ps

module tb_top import ppl_pkg::*; ;

  localparam int SLOTS   = 10;
  localparam int WORDS   = 256;
  localparam int ENTRIES = 256;

  typedef struct {
    op_t         op;
    logic [3:0]  slot;
    logic [7:0]  word_addr;
    logic [33:0] number_value;
    logic        range_start;
    logic        entry_last;
    logic [7:0]  entry_id;
    logic [15:0] tariff_value;
    logic [39:0] phone_digits;
    logic [3:0]  digit_count;
  } request_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  match_entry;
    logic [15:0] match_tariff;
    logic [3:0]  prefix_length;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [3:0]  in_slot = '0;
  logic [7:0]  in_word_addr = '0;
  logic [33:0] in_number_value = '0;
  logic        in_range_start = 1'b0;
  logic        in_entry_last = 1'b0;
  logic [7:0]  in_entry_id = '0;
  logic [15:0] in_tariff_value = '0;
  logic [39:0] in_phone_digits = '0;
  logic [3:0]  in_digit_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [7:0]  out_match_entry;
  logic [15:0] out_match_tariff;
  logic [3:0]  out_prefix_length;

  phone_prefix_range_lookup u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_slot          (in_slot),
    .in_word_addr     (in_word_addr),
    .in_number_value  (in_number_value),
    .in_range_start   (in_range_start),
    .in_entry_last    (in_entry_last),
    .in_entry_id      (in_entry_id),
    .in_tariff_value  (in_tariff_value),
    .in_phone_digits  (in_phone_digits),
    .in_digit_count   (in_digit_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_entry  (out_match_entry),
    .out_match_tariff (out_match_tariff),
    .out_prefix_length(out_prefix_length)
  );

  word_t       model_words [SLOTS][WORDS];
  int unsigned model_counts [SLOTS] = '{default: 0};
  logic [15:0] model_tariffs [ENTRIES];

  int unsigned     gen_counts [SLOTS] = '{default: 0};
  int unsigned     gen_written [SLOTS] = '{default: 0};
  longint unsigned gen_values [SLOTS][WORDS];
  int unsigned     gen_lengths [SLOTS][WORDS];
  bit              gen_tariff_ok [ENTRIES] = '{default: 1'b0};

  request_t pending_reqs [$];
  lookup_t  expected_lookups [$];

  request_t    bus_req;
  int unsigned total_reqs = 0;
  int unsigned sent_count = 0;
  int unsigned accepted_count = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned fail_count = 0;
  lookup_t     got_lookup;
  lookup_t     want_lookup;

  function automatic bit scan_slot(int unsigned s, longint unsigned val, output logic [7:0] id);
    int unsigned cnt;
    int unsigned i;
    bit          upper_ok;
    cnt = model_counts[s];
    id = '0;
    for (i = 0; i < cnt; i++) begin
      if (model_words[s][i].range_start) begin
        if (!model_words[s][i].entry_last && i + 1 < cnt) begin
          upper_ok = model_words[s][i + 1].range_start || val <= model_words[s][i + 1].value;
          if (model_words[s][i].value <= val && upper_ok) begin
            id = model_words[s][i].entry_id;
            return 1'b1;
          end
        end
      end else if (model_words[s][i].value == val) begin
        id = model_words[s][i].entry_id;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic lookup_t predict_lookup(logic [39:0] digits, logic [3:0] dcount);
    lookup_t         res;
    int unsigned     lim;
    int unsigned     first;
    int unsigned     d;
    int              k;
    longint unsigned val;
    logic [7:0]      id;
    res = '0;
    lim = dcount;
    if (lim > 10) lim = 10;
    first = digits[39:36];
    val = 0;
    if (lim == 0 || first > 9) return res;
    for (k = 0; k < lim; k++) begin
      d = digits[39 - 4 * k -: 4];
      if (d > 9) break;
      val = val * 10 + d;
      if (scan_slot(first, val, id)) begin
        res.found = 1'b1;
        res.match_entry = id;
        res.match_tariff = model_tariffs[id];
        res.prefix_length = 4'(k + 1);
        break;
      end
    end
    return res;
  endfunction

  function automatic void apply_request(request_t r);
    case (r.op)
      OP_LOAD_WORD: begin
        if (r.slot < SLOTS) begin
          model_words[r.slot][r.word_addr] =
            '{r.number_value, r.range_start, r.entry_last, r.entry_id};
          model_counts[r.slot] = r.word_addr + 1;
        end
      end
      OP_LOAD_TARIFF: model_tariffs[r.entry_id] = r.tariff_value;
      OP_CLEAR: begin
        foreach (model_counts[i]) model_counts[i] = 0;
      end
      OP_SEARCH: expected_lookups.push_back(predict_lookup(r.phone_digits, r.digit_count));
      default: ;
    endcase
  endfunction

  function automatic longint unsigned pow10(int unsigned n);
    longint unsigned p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  function automatic longint unsigned slot_number(int unsigned s, int unsigned len);
    return s * pow10(len - 1) + ($urandom % pow10(len - 1));
  endfunction

  function automatic logic [39:0] dial_digits(longint unsigned v, int unsigned len);
    logic [39:0] p;
    int          k;
    for (k = 0; k < 10; k++) begin
      if (k < len) p[39 - 4 * k -: 4] = 4'((v / pow10(len - 1 - k)) % 10);
      else p[39 - 4 * k -: 4] = 4'($urandom_range(0, 9));
    end
    if ($urandom_range(0, 9) == 0) p[39 - 4 * $urandom_range(1, 9) -: 4] = 4'($urandom_range(10, 15));
    return p;
  endfunction

  function automatic request_t random_fields();
    request_t r;
    r.op = op_t'($urandom_range(0, 3));
    r.slot = 4'($urandom);
    r.word_addr = 8'($urandom);
    r.number_value = {2'($urandom), 32'($urandom)};
    r.range_start = 1'($urandom);
    r.entry_last = 1'($urandom);
    r.entry_id = 8'($urandom);
    r.tariff_value = 16'($urandom);
    r.phone_digits = {8'($urandom), 32'($urandom)};
    r.digit_count = 4'($urandom);
    return r;
  endfunction

  function automatic void queue_tariff(logic [7:0] e, logic [15:0] t);
    request_t r;
    r = random_fields();
    r.op = OP_LOAD_TARIFF;
    r.entry_id = e;
    r.tariff_value = t;
    gen_tariff_ok[e] = 1'b1;
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_word(int unsigned s, int unsigned a, longint unsigned v,
                                     int unsigned len, bit rs, bit el, logic [7:0] e);
    request_t r;
    r = random_fields();
    if (!gen_tariff_ok[e]) queue_tariff(e, 16'($urandom));
    r.op = OP_LOAD_WORD;
    r.slot = 4'(s);
    r.word_addr = 8'(a);
    r.number_value = 34'(v);
    r.range_start = rs;
    r.entry_last = el;
    r.entry_id = e;
    if (s < SLOTS) begin
      if (a == gen_written[s]) gen_written[s]++;
      gen_counts[s] = a + 1;
      gen_values[s][a] = v;
      gen_lengths[s][a] = len;
    end
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_search(logic [39:0] p, logic [3:0] dc);
    request_t r;
    r = random_fields();
    r.op = OP_SEARCH;
    r.phone_digits = p;
    r.digit_count = dc;
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_clear();
    request_t r;
    r = random_fields();
    r.op = OP_CLEAR;
    foreach (gen_counts[i]) gen_counts[i] = 0;
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_random_search();
    int unsigned     s;
    int unsigned     i;
    int unsigned     len;
    int unsigned     pick;
    int unsigned     tries;
    longint unsigned v;
    logic [3:0]      dc;
    pick = $urandom_range(0, 99);
    s = $urandom_range(0, SLOTS - 1);
    for (tries = 0; tries < 10 && gen_counts[s] == 0; tries++) s = $urandom_range(0, SLOTS - 1);
    if (pick < 15) begin
      queue_search({8'($urandom), 32'($urandom)}, 4'($urandom));
    end else if (gen_counts[s] == 0) begin
      queue_search(dial_digits(slot_number(s, 10), 10), 4'($urandom));
    end else begin
      i = $urandom_range(0, gen_counts[s] - 1);
      v = gen_values[s][i];
      len = gen_lengths[s][i];
      if ($urandom_range(0, 99) < 30) v = v + $urandom_range(0, 20);
      pick = $urandom_range(0, 99);
      if (pick < 60) dc = 4'd10;
      else if (pick < 80) dc = 4'($urandom_range(len, 15));
      else dc = 4'($urandom_range(0, 15));
      queue_search(dial_digits(v % pow10(len), len), dc);
    end
  endfunction

  function automatic void queue_random_load();
    int unsigned     s;
    int unsigned     a;
    int unsigned     cap;
    int unsigned     len;
    longint unsigned lo;
    logic [7:0]      e;
    e = 8'($urandom);
    if ($urandom_range(0, 99) < 8) begin
      queue_word($urandom_range(SLOTS, 15), $urandom_range(0, 255), {2'($urandom), 32'($urandom)},
                 10, 1'($urandom), 1'($urandom), e);
      return;
    end
    s = $urandom_range(0, SLOTS - 1);
    cap = (s == 7) ? 60 : 20;
    if (gen_counts[s] < cap && $urandom_range(0, 99) < 85) a = gen_counts[s];
    else a = $urandom_range(0, (gen_written[s] < cap) ? gen_written[s] : cap);
    len = $urandom_range(1, 10);
    lo = slot_number(s, len);
    if ($urandom_range(0, 99) < 35) begin
      queue_word(s, a, lo, len, 1'b1, 1'b0, e);
      queue_word(s, a + 1, lo + $urandom_range(0, 500), len, $urandom_range(0, 9) == 0, 1'b1, e);
    end else begin
      queue_word(s, a, lo, len, $urandom_range(0, 19) == 0, 1'($urandom), e);
    end
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned pick;
    int unsigned target;

    queue_search(40'h5123456789, 4'd10);
    queue_tariff(8'd255, 16'hFFFF);
    queue_tariff(8'd1, 16'h0000);
    queue_word(5, 0, 51, 2, 1'b0, 1'b1, 8'd1);
    queue_word(5, 1, 520, 3, 1'b1, 1'b0, 8'd2);
    queue_word(5, 2, 529, 3, 1'b0, 1'b1, 8'd2);
    queue_word(5, 3, 5300, 4, 1'b1, 1'b0, 8'd3);
    queue_word(5, 4, 0, 1, 1'b1, 1'b1, 8'd3);
    queue_word(5, 5, 34'h3FFFFFFFF, 10, 1'b1, 1'b0, 8'd255);
    queue_word(9, 0, 9876543210, 10, 1'b0, 1'b1, 8'd255);
    queue_search(40'h5100000000, 4'd10);
    queue_search(40'h5250000000, 4'd3);
    queue_search(40'h5300123456, 4'd10);
    queue_search(40'h5290000000, 4'd1);
    queue_search(40'h5F00000000, 4'd10);
    queue_search(40'hF512345678, 4'd10);
    queue_search(40'hA500000000, 4'd10);
    queue_search(40'h5999999999, 4'd15);
    queue_search(40'h5123000000, 4'd0);
    queue_search(40'hFFFFFFFFFF, 4'hF);
    queue_search(40'h9876543210, 4'd10);
    queue_word(12, 255, 34'h3FFFFFFFF, 10, 1'b1, 1'b1, 8'hAA);
    queue_clear();
    queue_search(40'h5100000000, 4'd10);
    queue_word(5, 2, 529, 3, 1'b0, 1'b1, 8'd2);
    queue_search(40'h5250000000, 4'd10);

    target = 230;
    while (pending_reqs.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) queue_random_search();
      else if (pick < 85) queue_random_load();
      else if (pick < 94) queue_tariff(8'($urandom), 16'($urandom));
      else queue_clear();
    end
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_reqs) @(negedge clk);
    while (expected_lookups.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("** phone_prefix_range_lookup: PASSED **");
    end else begin
      $display("** phone_prefix_range_lookup: FAILED **");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("** phone_prefix_range_lookup: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(bus_req);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 &&
            ((sent_count >= 60 && sent_count < 120) || $urandom_range(0, 99) >= 31)) begin
          bus_req = pending_reqs.pop_front();
          sent_count++;
          in_valid <= 1'b1;
          in_op <= bus_req.op;
          in_slot <= bus_req.slot;
          in_word_addr <= bus_req.word_addr;
          in_number_value <= bus_req.number_value;
          in_range_start <= bus_req.range_start;
          in_entry_last <= bus_req.entry_last;
          in_entry_id <= bus_req.entry_id;
          in_tariff_value <= bus_req.tariff_value;
          in_phone_digits <= bus_req.phone_digits;
          in_digit_count <= bus_req.digit_count;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_lookup = {out_found, out_match_entry, out_match_tariff, out_prefix_length};
        results_seen++;
        if (expected_lookups.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected lookup result at %0t: found=%0b entry=%0d tariff=%0d length=%0d",
                     $time, got_lookup.found, got_lookup.match_entry, got_lookup.match_tariff,
                     got_lookup.prefix_length);
        end else begin
          want_lookup = expected_lookups.pop_front();
          if (got_lookup !== want_lookup) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"lookup mismatch at %0t: expected found=%0b entry=%0d tariff=%0d ",
                        "length=%0d, got found=%0b entry=%0d tariff=%0d length=%0d"},
                       $time, want_lookup.found, want_lookup.match_entry,
                       want_lookup.match_tariff, want_lookup.prefix_length, got_lookup.found,
                       got_lookup.match_entry, got_lookup.match_tariff,
                       got_lookup.prefix_length);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen == 15) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= 40 && results_seen < 70) || $urandom_range(0, 99) >= 31;
      end
    end
  end

endmodule
